// ===== rtl/core/cwst_pkg.sv =====
// Shared types and constants for the wide Collatz stopping-time block.
// No dependencies; imported by every module of the block.
package cwst_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned EXP_W   = 10;
  localparam int unsigned REM_W   = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef logic [WORD_W-1:0] word_t;

  // per-word control for the word step unit
  typedef struct packed {
    logic first;  // lowest word of a pass
    logic last;   // highest word of a pass
    logic odd;    // 3x+1 pass when set, halving pass otherwise
  } alu_ctl_t;

endpackage

// ===== rtl/core/cwst_word_alu.sv =====
// One 64-bit word of a Collatz step: halving or 3x+1 with carry chain.
// Depends on cwst_pkg.
module cwst_word_alu
  import cwst_pkg::*;
(
  input  word_t    cur_i,
  input  word_t    nxt_i,
  input  alu_ctl_t ctl_i,
  input  logic [1:0] carry_i,
  input  logic     hi_i,
  output word_t    word_o,
  output logic [1:0] carry_o,
  output logic     hi_o
);

  logic [1:0]        carry_in;
  logic              hi_in;
  word_t             dbl;
  logic [WORD_W+1:0] sum;

  always_comb begin
    // the +1 of 3x+1 enters as the carry into the lowest word
    carry_in = ctl_i.first ? 2'd1 : carry_i;
    hi_in    = ctl_i.first ? 1'b0 : hi_i;
    dbl      = {cur_i[WORD_W-2:0], hi_in};
    sum      = {2'b00, cur_i} + {2'b00, dbl} + {{WORD_W{1'b0}}, carry_in};
    hi_o     = cur_i[WORD_W-1];
    if (ctl_i.odd) begin
      word_o  = sum[WORD_W-1:0];
      carry_o = sum[WORD_W+1:WORD_W];
    end else begin
      word_o  = {(ctl_i.last ? 1'b0 : nxt_i[0]), cur_i[WORD_W-1:1]};
      carry_o = 2'd0;
    end
  end

endmodule

// ===== rtl/core/cwst_value_shreg.sv =====
// Rotating word shift register holding the wide value, with start-value loader.
// Depends on cwst_pkg.
module cwst_value_shreg
  import cwst_pkg::*;
#(
  parameter int unsigned WORDS = 16
) (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic [EXP_W-1:0] exp_i,
  input  logic             shift_i,
  input  word_t            word_i,
  output word_t            head_o,
  output word_t            next_o
);

  localparam int unsigned NEXT_IDX = (WORDS > 1) ? 1 : 0;

  word_t words_q [WORDS];

  // word idx of 2^n - 1
  function automatic word_t init_word(input int unsigned idx, input logic [EXP_W-1:0] n);
    int unsigned full;
    logic [REM_W-1:0] rem;
    word_t w;
    full = int'(n[EXP_W-1:REM_W]);
    rem  = n[REM_W-1:0];
    if (full > idx) w = '1;
    else if (full == idx) w = (word_t'(1) << rem) - word_t'(1);
    else w = '0;
    return w;
  endfunction

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int unsigned i = 0; i < WORDS; i++) words_q[i] <= init_word(i, exp_i);
    end else if (shift_i) begin
      for (int unsigned i = 0; i + 1 < WORDS; i++) words_q[i] <= words_q[i+1];
      words_q[WORDS-1] <= word_i;
    end
  end

  assign head_o = words_q[0];
  assign next_o = words_q[NEXT_IDX];

endmodule

// ===== rtl/core/collatz_wide_stopping_time.sv =====
// Wide Collatz total stopping time of 2^n - 1, word-serial datapath.
// Each Collatz step is one pass of the
// 64-bit word unit over the WORDS = ceil(VALUE_WIDTH/64) words of the value.
// Throughput: one item at a time; busy is high from the transfer to the result, except for too wide an exponent.
// An exponent wider than the register gives its result in the cycle after the transfer.
// rst_ni clears control state asynchronously; the receiver cannot stall done_o.
module collatz_wide_stopping_time
  import cwst_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH  = 1024,
  parameter int unsigned MAX_EXPONENT = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [EXP_W-1:0]   start_exponent_i,
  output logic               busy,
  output logic               done_o,
  output logic [COUNT_W-1:0] step_count_o,
  output logic               overflowed_o
);

  localparam int unsigned WORDS    = (VALUE_WIDTH + WORD_W - 1) / WORD_W;
  localparam int unsigned TOP_BITS = VALUE_WIDTH - WORD_W * (WORDS - 1);
  localparam int unsigned CNT_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam word_t TOP_MASK = (TOP_BITS >= WORD_W) ? '1
                             : ((word_t'(1) << (TOP_BITS % WORD_W)) - word_t'(1));

  typedef enum logic {S_IDLE, S_RUN} state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [COUNT_W-1:0] steps_q;
  logic               op_odd_q;   // kind of the pass in flight
  logic               acc_q;      // value above 1 seen so far in this pass
  logic               le1_q;      // value known to be 0 or 1
  logic [1:0]         carry_q;
  logic               hi_q;

  logic [EXP_W-1:0]   n_sat;
  logic               accept;
  logic               too_wide;

  word_t     head, nxt, alu_word;
  alu_ctl_t  ctl;
  logic [1:0] alu_carry;
  logic       alu_hi;
  logic       first, last, stop_now, shift, acc_now, ovf;

  // exponent saturation; the bound may exceed what the input can carry
  always_comb begin
    if (32'(start_exponent_i) > MAX_EXPONENT) n_sat = EXP_W'(MAX_EXPONENT);
    else n_sat = start_exponent_i;
  end

  assign accept   = start && !busy;
  assign too_wide = 32'(n_sat) > VALUE_WIDTH;

  // pass sequencing: cnt_q walks the words, lowest first
  assign first    = (cnt_q == '0);
  assign last     = (cnt_q == CNT_W'(WORDS - 1));
  // a new step is decided at the top of each pass
  assign stop_now = (state_q == S_RUN) && first && (le1_q || steps_q == COUNT_MAX);
  assign shift    = (state_q == S_RUN) && !stop_now;

  assign ctl.first = first;
  assign ctl.last  = last;
  assign ctl.odd   = first ? head[0] : op_odd_q;

  cwst_value_shreg #(.WORDS(WORDS)) u_value (
    .clk_i   (clk_i),
    .load_i  (accept),
    .exp_i   (n_sat),
    .shift_i (shift),
    .word_i  (alu_word),
    .head_o  (head),
    .next_o  (nxt)
  );

  cwst_word_alu u_alu (
    .cur_i   (head),
    .nxt_i   (nxt),
    .ctl_i   (ctl),
    .carry_i (carry_q),
    .hi_i    (hi_q),
    .word_o  (alu_word),
    .carry_o (alu_carry),
    .hi_o    (alu_hi)
  );

  // new value > 1: lowest word above 1, or any higher word nonzero
  assign acc_now = (first ? 1'b0 : acc_q) |
                   (first ? (alu_word > word_t'(1)) : (alu_word != '0));
  // 3x+1 result needs more than VALUE_WIDTH bits
  assign ovf = ctl.odd && ((alu_carry != 2'd0) || alu_hi || ((alu_word & ~TOP_MASK) != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      steps_q      <= '0;
      op_odd_q     <= 1'b0;
      acc_q        <= 1'b0;
      le1_q        <= 1'b0;
      carry_q      <= 2'd0;
      hi_q         <= 1'b0;
      done_o       <= 1'b0;
      step_count_o <= '0;
      overflowed_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            steps_q <= '0;
            cnt_q   <= '0;
            le1_q   <= (n_sat <= EXP_W'(1));
            if (too_wide) begin
              done_o       <= 1'b1;
              step_count_o <= '0;
              overflowed_o <= 1'b1;
            end else begin
              state_q <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (stop_now) begin
            done_o       <= 1'b1;
            step_count_o <= steps_q;
            overflowed_o <= 1'b0;
            state_q      <= S_IDLE;
          end else begin
            if (first) op_odd_q <= ctl.odd;
            carry_q <= alu_carry;
            hi_q    <= alu_hi;
            acc_q   <= acc_now;
            if (last) begin
              cnt_q <= '0;
              if (ovf) begin
                // overflowing step is not counted
                done_o       <= 1'b1;
                step_count_o <= steps_q;
                overflowed_o <= 1'b1;
                state_q      <= S_IDLE;
              end else begin
                steps_q <= steps_q + COUNT_W'(1);
                le1_q   <= !acc_now;
              end
            end else begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/core/cwst_checker.sv =====
// Port-level checks for collatz_wide_stopping_time, bound to the top level.
// Depends on cwst_pkg.
module cwst_checker
  import cwst_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic [EXP_W-1:0]   start_exponent_i,
  input logic               busy,
  input logic               done_o,
  input logic [COUNT_W-1:0] step_count_o,
  input logic               overflowed_o
);

  // start values 0 and 1 finish at once with no steps
  a_trivial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && start_exponent_i <= EXP_W'(1)) |->
      ##2 (done_o && step_count_o == '0 && !overflowed_o))
    else $error("trivial exponent did not finish with zero steps");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start transfer");

  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy fell without a result");

endmodule

bind collatz_wide_stopping_time cwst_checker u_cwst_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .start_exponent_i (start_exponent_i),
  .busy             (busy),
  .done_o           (done_o),
  .step_count_o     (step_count_o),
  .overflowed_o     (overflowed_o)
);
